// ----- hw/rtl/rde_pkg.sv -----
// ----------------------------------------------------------------------------
// rde_pkg: shared types and constants of the repeating decimal expander
// Field widths, default sizes, engine state codes and the result bundle.
// ----------------------------------------------------------------------------
package rde_pkg;

    // default sizes, used as the top level's parameter defaults
    localparam int DEF_MAX_DENOMINATOR = 4096;
    localparam int DEF_SHOWN_DIGITS    = 50;
    localparam int DEF_NUMERATOR_WIDTH = 16;

    // request queue between front and engine
    localparam int QUEUE_DEPTH = 2;

    // fixed field widths
    localparam int DEN_W   = 12;
    localparam int IP_W    = 16;
    localparam int DIGIT_W = 4;
    localparam int IDX_W   = 6;
    localparam int CLEN_W  = 12;

    // long division in base ten
    localparam int BASE     = 10;
    localparam int NUM_MULT = BASE - 1;
    localparam int PROD_W   = DEN_W + 4;   // remainder times ten
    localparam int POS_W    = DEN_W;       // digit position / count

    // engine sequencer
    typedef enum logic [2:0] {
        ENG_IDLE,
        ENG_BAD,
        ENG_DIV,
        ENG_CLEAR,
        ENG_PRIME,
        ENG_RUN,
        ENG_EMIT_RD,
        ENG_EMIT_WR
    } eng_state_t;

    // one result of a run
    typedef struct packed {
        logic [IP_W-1:0]    integer_part;
        logic [DIGIT_W-1:0] digit;
        logic [IDX_W-1:0]   digit_index;
        logic               cycle_starts_here;
        logic [CLEN_W-1:0]  cycle_length;
        logic               truncated;
        logic               last;
    } rde_result_t;

endpackage

// ----- hw/rtl/rde_front.sv -----
// ----------------------------------------------------------------------------
// rde_front: request intake
// Registers an incoming request and flags a denominator that is zero or too
// large for the remainder table, then hands it to the queue.
// ----------------------------------------------------------------------------
module rde_front
    import rde_pkg::*;
#(
    parameter int MAX_DENOMINATOR = DEF_MAX_DENOMINATOR,
    parameter int NUMERATOR_WIDTH = DEF_NUMERATOR_WIDTH
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [NUMERATOR_WIDTH-1:0] numerator,
    input  logic [DEN_W-1:0]           denominator,
    output logic                       q_valid,
    input  logic                       q_ready,
    output logic [NUMERATOR_WIDTH-1:0] q_num,
    output logic [DEN_W-1:0]           q_den,
    output logic                       q_bad
);

    logic                       valid_reg, valid_next;
    logic [NUMERATOR_WIDTH-1:0] num_reg;
    logic [DEN_W-1:0]           den_reg;
    logic                       bad_reg;
    logic                       accept;
    logic                       bad_in;

    // stage is free when empty or draining this cycle
    assign in_ready = !valid_reg || q_ready;
    assign accept   = in_valid && in_ready;

    // classify: no expansion for zero or oversized denominator
    assign bad_in = (denominator == '0) || (32'(denominator) >= MAX_DENOMINATOR);

    always_comb
    begin
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (q_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            num_reg <= numerator;
            den_reg <= denominator;
            bad_reg <= bad_in;
        end
    end

    assign q_valid = valid_reg;
    assign q_num   = num_reg;
    assign q_den   = den_reg;
    assign q_bad   = bad_reg;

endmodule

// ----- hw/rtl/rde_fifo.sv -----
// ----------------------------------------------------------------------------
// rde_fifo: short request queue
// Register-based first-in first-out queue between intake and engine.
// ----------------------------------------------------------------------------
module rde_fifo
    import rde_pkg::*;
#(
    parameter int WIDTH = DEN_W + DEF_NUMERATOR_WIDTH + 1,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output logic [WIDTH-1:0] rd_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             push, pop;

    assign wr_ready = (cnt_reg != CW'(DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_data  = slot_reg[rd_ptr_reg];

    // pointer and fill update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ----- hw/rtl/rde_engine.sv -----
// ----------------------------------------------------------------------------
// rde_engine: long-division engine
// Takes one request from the queue, finds quotient and remainder with a
// bit-serial divider, clears the remainder table, expands one decimal digit
// per cycle until a remainder repeats, then streams the shown digits out.
// ----------------------------------------------------------------------------
module rde_engine
    import rde_pkg::*;
#(
    parameter int MAX_DENOMINATOR = DEF_MAX_DENOMINATOR,
    parameter int SHOWN_DIGITS    = DEF_SHOWN_DIGITS,
    parameter int NUMERATOR_WIDTH = DEF_NUMERATOR_WIDTH
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_valid,
    output logic                       q_ready,
    input  logic [NUMERATOR_WIDTH-1:0] q_num,
    input  logic [DEN_W-1:0]           q_den,
    input  logic                       q_bad,
    output logic                       out_valid,
    input  logic                       out_ready,
    output rde_result_t                res
);

    localparam int NW    = NUMERATOR_WIDTH;
    localparam int DC_W  = $clog2(NW);
    localparam int SA_W  = $clog2(MAX_DENOMINATOR);
    localparam int SE_W  = POS_W + 1;
    localparam int DS_AW = (SHOWN_DIGITS > 1) ? $clog2(SHOWN_DIGITS) : 1;

    // sequencer and datapath registers
    eng_state_t          state_reg, state_next;
    logic [NW-1:0]       quo_reg, quo_next;
    logic [DEN_W-1:0]    r_reg, r_next;
    logic [DEN_W-1:0]    den_reg, den_next;
    logic [PROD_W-1:0]   mult_reg [BASE];
    logic [PROD_W-1:0]   mult_next [BASE];
    logic [DC_W-1:0]     div_cnt_reg, div_cnt_next;
    logic [DEN_W-1:0]    clr_reg, clr_next;
    logic [POS_W-1:0]    cnt_reg, cnt_next;
    logic                byp_reg, byp_next;
    logic [POS_W-1:0]    byp_pos_reg, byp_pos_next;
    logic [POS_W-1:0]    start_reg, start_next;
    logic [CLEN_W-1:0]   clen_reg, clen_next;
    logic                trunc_reg, trunc_next;
    logic [IDX_W-1:0]    shown_m1_reg, shown_m1_next;
    logic [IDX_W-1:0]    emit_idx_reg, emit_idx_next;
    logic                out_valid_reg, out_valid_next;
    rde_result_t         res_reg, res_next;

    // remainder table: seen flag over first position
    logic [SE_W-1:0]     seen_mem [MAX_DENOMINATOR];
    logic [SE_W-1:0]     seen_rd_q;
    logic                seen_we;
    logic [SA_W-1:0]     seen_wa, seen_ra;
    logic [SE_W-1:0]     seen_wd;

    // shown digit store
    logic [DIGIT_W-1:0]  ds_mem [SHOWN_DIGITS];
    logic [DIGIT_W-1:0]  ds_q;
    logic                ds_we, ds_re;

    // combinational step values
    logic                pop;
    logic                out_free;
    logic [DEN_W:0]      div_t;
    logic [DEN_W:0]      div_diff;
    logic                div_ge;
    logic [PROD_W-1:0]   prod;
    logic [DIGIT_W-1:0]  digit_d;
    logic [PROD_W-1:0]   rem_full;
    logic [DEN_W-1:0]    new_r;
    logic                seen_hit;
    logic [POS_W-1:0]    seen_pos;
    logic                cnt_over;

    assign q_ready  = (state_reg == ENG_IDLE);
    assign pop      = q_valid && q_ready;
    assign out_free = !out_valid_reg || out_ready;

    // divider step: one quotient bit per cycle
    assign div_t    = {r_reg, quo_reg[NW-1]};
    assign div_diff = div_t - {1'b0, den_reg};
    assign div_ge   = (div_t >= {1'b0, den_reg});

    // digit step: compare remainder times ten against the multiples of den
    assign prod = (PROD_W'(r_reg) << 3) + (PROD_W'(r_reg) << 1);

    always_comb
    begin
        digit_d = '0;
        for (int k = 1; k <= NUM_MULT; k++)
        begin
            if (prod >= mult_reg[k])
            begin
                digit_d = DIGIT_W'(k);
            end
        end
    end

    assign rem_full = prod - mult_reg[digit_d];
    assign new_r    = rem_full[DEN_W-1:0];

    // a remainder written in the cycle it is read shows up through the bypass
    assign seen_hit = seen_rd_q[POS_W] || byp_reg;
    assign seen_pos = byp_reg ? byp_pos_reg : seen_rd_q[POS_W-1:0];
    assign cnt_over = (32'(cnt_reg) > SHOWN_DIGITS);

    // next state and datapath control
    always_comb
    begin
        state_next     = state_reg;
        quo_next       = quo_reg;
        r_next         = r_reg;
        den_next       = den_reg;
        mult_next      = mult_reg;
        div_cnt_next   = div_cnt_reg;
        clr_next       = clr_reg;
        cnt_next       = cnt_reg;
        byp_next       = byp_reg;
        byp_pos_next   = byp_pos_reg;
        start_next     = start_reg;
        clen_next      = clen_reg;
        trunc_next     = trunc_reg;
        shown_m1_next  = shown_m1_reg;
        emit_idx_next  = emit_idx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        res_next       = res_reg;
        seen_we        = 1'b0;
        seen_wa        = SA_W'(r_reg);
        seen_wd        = '0;
        seen_ra        = SA_W'(r_reg);
        ds_we          = 1'b0;
        ds_re          = 1'b0;

        unique case (state_reg)
            ENG_IDLE:
            begin
                if (pop)
                begin
                    quo_next     = q_num;
                    r_next       = '0;
                    den_next     = q_den;
                    div_cnt_next = '0;
                    clr_next     = '0;
                    for (int k = 0; k < BASE; k++)
                    begin
                        mult_next[k] = PROD_W'(q_den) * PROD_W'(k);
                    end
                    state_next = q_bad ? ENG_BAD : ENG_DIV;
                end
            end

            // single fixed result for an unusable denominator
            ENG_BAD:
            begin
                if (out_free)
                begin
                    res_next.integer_part      = '1;
                    res_next.digit             = '0;
                    res_next.digit_index       = '0;
                    res_next.cycle_starts_here = 1'b1;
                    res_next.cycle_length      = CLEN_W'(1);
                    res_next.truncated         = 1'b0;
                    res_next.last              = 1'b1;
                    out_valid_next             = 1'b1;
                    state_next                 = ENG_IDLE;
                end
            end

            ENG_DIV:
            begin
                r_next       = div_ge ? div_diff[DEN_W-1:0] : div_t[DEN_W-1:0];
                quo_next     = {quo_reg[NW-2:0], div_ge};
                div_cnt_next = div_cnt_reg + DC_W'(1);
                if (div_cnt_reg == DC_W'(NW - 1))
                begin
                    state_next = ENG_CLEAR;
                end
            end

            // wipe table entries below the denominator
            ENG_CLEAR:
            begin
                seen_we  = 1'b1;
                seen_wa  = SA_W'(clr_reg);
                seen_wd  = '0;
                clr_next = clr_reg + DEN_W'(1);
                if (clr_reg == den_reg - DEN_W'(1))
                begin
                    state_next = ENG_PRIME;
                end
            end

            // first table read for the starting remainder
            ENG_PRIME:
            begin
                seen_ra    = SA_W'(r_reg);
                cnt_next   = '0;
                byp_next   = 1'b0;
                state_next = ENG_RUN;
            end

            ENG_RUN:
            begin
                if (seen_hit)
                begin
                    start_next    = seen_pos;
                    clen_next     = CLEN_W'(cnt_reg - seen_pos);
                    trunc_next    = cnt_over;
                    shown_m1_next = cnt_over ? IDX_W'(SHOWN_DIGITS - 1)
                                             : IDX_W'(cnt_reg - POS_W'(1));
                    emit_idx_next = '0;
                    state_next    = ENG_EMIT_RD;
                end
                else
                begin
                    seen_we      = 1'b1;
                    seen_wa      = SA_W'(r_reg);
                    seen_wd      = {1'b1, cnt_reg};
                    ds_we        = (32'(cnt_reg) < SHOWN_DIGITS);
                    seen_ra      = SA_W'(new_r);
                    byp_next     = (new_r == r_reg);
                    byp_pos_next = cnt_reg;
                    r_next       = new_r;
                    cnt_next     = cnt_reg + POS_W'(1);
                end
            end

            ENG_EMIT_RD:
            begin
                ds_re      = 1'b1;
                state_next = ENG_EMIT_WR;
            end

            ENG_EMIT_WR:
            begin
                if (out_free)
                begin
                    res_next.integer_part      = IP_W'(quo_reg);
                    res_next.digit             = ds_q;
                    res_next.digit_index       = emit_idx_reg;
                    res_next.cycle_starts_here = (POS_W'(emit_idx_reg) == start_reg);
                    res_next.cycle_length      = clen_reg;
                    res_next.truncated         = trunc_reg;
                    res_next.last              = (emit_idx_reg == shown_m1_reg);
                    out_valid_next             = 1'b1;
                    if (emit_idx_reg == shown_m1_reg)
                    begin
                        state_next = ENG_IDLE;
                    end
                    else
                    begin
                        emit_idx_next = emit_idx_reg + IDX_W'(1);
                        state_next    = ENG_EMIT_RD;
                    end
                end
            end

            default:
            begin
                state_next = ENG_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ENG_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        quo_reg      <= quo_next;
        r_reg        <= r_next;
        den_reg      <= den_next;
        mult_reg     <= mult_next;
        div_cnt_reg  <= div_cnt_next;
        clr_reg      <= clr_next;
        cnt_reg      <= cnt_next;
        byp_reg      <= byp_next;
        byp_pos_reg  <= byp_pos_next;
        start_reg    <= start_next;
        clen_reg     <= clen_next;
        trunc_reg    <= trunc_next;
        shown_m1_reg <= shown_m1_next;
        emit_idx_reg <= emit_idx_next;
        res_reg      <= res_next;
    end

    // remainder table, registered read
    always_ff @(posedge clk)
    begin
        if (seen_we)
        begin
            seen_mem[seen_wa] <= seen_wd;
        end
        seen_rd_q <= seen_mem[seen_ra];
    end

    // digit store, registered read
    always_ff @(posedge clk)
    begin
        if (ds_we)
        begin
            ds_mem[DS_AW'(cnt_reg)] <= digit_d;
        end
        if (ds_re)
        begin
            ds_q <= ds_mem[DS_AW'(emit_idx_reg)];
        end
    end

    assign out_valid = out_valid_reg;
    assign res       = res_reg;

endmodule

// ----- hw/rtl/repeating_decimal_expander.sv -----
// ----------------------------------------------------------------------------
// repeating_decimal_expander: decimal expansion with repeat detection
// Expands numerator/denominator by base-ten long division, one result per shown
// fractional digit, marking where the repeating cycle starts and its length.
//
//   Channel   Handshake              Payload
//   -------   --------------------   ---------------------------------------
//   input     in_valid / in_ready    numerator, denominator
//   output    out_valid / out_ready  integer_part, digit, digit_index,
//                                    cycle_starts_here, cycle_length,
//                                    truncated, last
//
// A request passes the intake register and the queue to the engine, which takes
// it, runs the serial divider over the NUMERATOR_WIDTH numerator bits, clears
// the remainder table below the denominator (one entry per write), expands a
// digit per distinct remainder and emits each shown digit via a read state and
// a write state. After reset the block accepts at once. The intake register and
// a two-entry queue keep accepting while the engine runs or output waits.
// ----------------------------------------------------------------------------
module repeating_decimal_expander
    import rde_pkg::*;
#(
    parameter int MAX_DENOMINATOR = DEF_MAX_DENOMINATOR,
    parameter int SHOWN_DIGITS    = DEF_SHOWN_DIGITS,
    parameter int NUMERATOR_WIDTH = DEF_NUMERATOR_WIDTH
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [NUMERATOR_WIDTH-1:0] numerator,
    input  logic [DEN_W-1:0]           denominator,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [IP_W-1:0]            integer_part,
    output logic [DIGIT_W-1:0]         digit,
    output logic [IDX_W-1:0]           digit_index,
    output logic                       cycle_starts_here,
    output logic [CLEN_W-1:0]          cycle_length,
    output logic                       truncated,
    output logic                       last
);

    localparam int QW = NUMERATOR_WIDTH + DEN_W + 1;

    logic                       f_valid, f_ready;
    logic [NUMERATOR_WIDTH-1:0] f_num;
    logic [DEN_W-1:0]           f_den;
    logic                       f_bad;
    logic                       e_valid, e_ready;
    logic [QW-1:0]              e_data;
    rde_result_t                res;

    // intake and classification
    rde_front #(
        .MAX_DENOMINATOR (MAX_DENOMINATOR),
        .NUMERATOR_WIDTH (NUMERATOR_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .numerator   (numerator),
        .denominator (denominator),
        .q_valid     (f_valid),
        .q_ready     (f_ready),
        .q_num       (f_num),
        .q_den       (f_den),
        .q_bad       (f_bad)
    );

    // request queue
    rde_fifo #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  ({f_bad, f_den, f_num}),
        .rd_valid (e_valid),
        .rd_ready (e_ready),
        .rd_data  (e_data)
    );

    // division and expansion
    rde_engine #(
        .MAX_DENOMINATOR (MAX_DENOMINATOR),
        .SHOWN_DIGITS    (SHOWN_DIGITS),
        .NUMERATOR_WIDTH (NUMERATOR_WIDTH)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (e_valid),
        .q_ready   (e_ready),
        .q_num     (e_data[NUMERATOR_WIDTH-1:0]),
        .q_den     (e_data[NUMERATOR_WIDTH +: DEN_W]),
        .q_bad     (e_data[QW-1]),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res       (res)
    );

    assign integer_part      = res.integer_part;
    assign digit             = res.digit;
    assign digit_index       = res.digit_index;
    assign cycle_starts_here = res.cycle_starts_here;
    assign cycle_length      = res.cycle_length;
    assign truncated         = res.truncated;
    assign last              = res.last;

endmodule

// ----- sim/tb_repeating_decimal_expander.sv -----
// ----------------------------------------------------------------------------
// tb_repeating_decimal_expander: self-checking bench for the decimal expander
// Requests are queued by a stimulus block and driven on the input channel.
// A monitor predicts the expected digits for every accepted request by
// base-ten long division and compares each output result field by field.
// Phases vary sender idling and receiver stalls, and one phase holds the
// output off long enough to back the block up to its input.
// ----------------------------------------------------------------------------
module tb_repeating_decimal_expander;
    import rde_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_W        = DEF_NUMERATOR_WIDTH;
    localparam int MAX_DEN      = DEF_MAX_DENOMINATOR;
    localparam int SHOWN        = DEF_SHOWN_DIGITS;
    localparam int CYCLE_LIMIT  = 10_000_000;
    localparam int DRAIN_CYCLES = 4400;
    localparam int HOLD_CYCLES  = 600;
    localparam int RANDOM_PER_PHASE = 28;
    localparam int MAX_PRINTS   = 60;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } fraction_t;

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                in_valid    = 1'b0;
    logic                in_ready;
    logic [NUM_W-1:0]    numerator   = '0;
    logic [DEN_W-1:0]    denominator = '0;
    logic                out_valid;
    logic                out_ready   = 1'b0;
    logic [IP_W-1:0]     integer_part;
    logic [DIGIT_W-1:0]  digit;
    logic [IDX_W-1:0]    digit_index;
    logic                cycle_starts_here;
    logic [CLEN_W-1:0]   cycle_length;
    logic                truncated;
    logic                last;

    fraction_t   request_queue[$];
    rde_result_t expected_digits[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int error_count    = 0;
    int cycle_count    = 0;

    // long hold-off on the output side
    logic hold_arm  = 1'b0;
    logic hold_used = 1'b0;
    int   hold_left = 0;

    // scratch tables of the predictor
    bit         rem_hit   [0:MAX_DEN-1];
    int         rem_first [0:MAX_DEN-1];
    logic [3:0] digit_buf [0:SHOWN-1];

    repeating_decimal_expander u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .numerator         (numerator),
        .denominator       (denominator),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .integer_part      (integer_part),
        .digit             (digit),
        .digit_index       (digit_index),
        .cycle_starts_here (cycle_starts_here),
        .cycle_length      (cycle_length),
        .truncated         (truncated),
        .last              (last)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // mismatch report: one line, counted
    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        if (error_count <= MAX_PRINTS)
            $display("mismatch %s: got %0d expected %0d", what, got, want);
    endtask

    // append one predicted result
    function automatic void add_expected(input rde_result_t r);
        expected_digits.insert(expected_digits.size(), r);
    endfunction

    // append one pending request
    function automatic void add_request(input logic [NUM_W-1:0] n,
                                        input logic [DEN_W-1:0] d);
        fraction_t f;
        f.num = n;
        f.den = d;
        request_queue.insert(request_queue.size(), f);
    endfunction

    // long division with repeat detection; queues the expected digits
    function automatic void expand_fraction(input logic [NUM_W-1:0] num,
                                            input logic [DEN_W-1:0] den);
        rde_result_t r;
        int k;
        int rem;
        int prod;
        int count;
        int start;
        int shown;
        bit trunc;
        if (den == '0 || int'(den) >= MAX_DEN)
        begin
            // unusable denominator: single all-ones result
            r = '0;
            r.integer_part      = '1;
            r.cycle_starts_here = 1'b1;
            r.cycle_length      = CLEN_W'(1);
            r.last              = 1'b1;
            add_expected(r);
            return;
        end
        for (k = 0; k < MAX_DEN; k++)
            rem_hit[k] = 1'b0;
        rem   = int'(num) % int'(den);
        count = 0;
        while (!rem_hit[rem])
        begin
            prod           = rem * BASE;
            rem_hit[rem]   = 1'b1;
            rem_first[rem] = count;
            if (count < SHOWN)
                digit_buf[count] = 4'(prod / int'(den));
            rem = prod % int'(den);
            count++;
        end
        start = rem_first[rem];
        trunc = (count > SHOWN);
        shown = trunc ? SHOWN : count;
        for (k = 0; k < shown; k++)
        begin
            r.integer_part      = IP_W'(int'(num) / int'(den));
            r.digit             = digit_buf[k];
            r.digit_index       = IDX_W'(k);
            r.cycle_starts_here = (k == start);
            r.cycle_length      = CLEN_W'(count - start);
            r.truncated         = trunc;
            r.last              = (k + 1 == shown);
            add_expected(r);
        end
    endfunction

    // random request, biased toward small denominators to keep runs short
    task automatic queue_random(input int n);
        fraction_t f;
        int pick;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
                f.num = '0;
            else if (pick < 14)
                f.num = '1;
            else if (pick < 30)
                f.num = NUM_W'($urandom_range(0, 99));
            else
                f.num = NUM_W'($urandom_range(0, 65535));
            pick = $urandom_range(99);
            if (pick < 55)
                f.den = DEN_W'($urandom_range(1, 60));
            else if (pick < 78)
                f.den = DEN_W'($urandom_range(61, 400));
            else if (pick < 95)
                f.den = DEN_W'($urandom_range(401, 4095));
            else if (pick < 97)
                f.den = '0;
            else
                f.den = '1;
            add_request(f.num, f.den);
        end
    endtask

    // wait until every queued request has been taken and answered
    task automatic wait_drained();
        while (request_queue.size() != 0 || in_valid || expected_digits.size() != 0)
            @(negedge clk);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            numerator   <= '0;
            denominator <= '0;
        end
        else if (!in_valid || in_ready)
        begin
            if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_valid    <= 1'b1;
                numerator   <= request_queue[0].num;
                denominator <= request_queue[0].den;
                void'(request_queue.pop_front());
            end
            else
                in_valid <= 1'b0;
        end
    end

    // hold-off counter for the backpressure phase
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_used <= 1'b0;
        end
        else if (hold_arm && !hold_used)
        begin
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // monitor: predict on accepted requests, check accepted results
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
                expand_fraction(numerator, denominator);
            if (out_valid && out_ready)
            begin
                if (expected_digits.size() == 0)
                    report_mismatch("result with none pending, index",
                                    int'(digit_index), 0);
                else
                begin
                    if (integer_part != expected_digits[0].integer_part)
                        report_mismatch("integer_part", int'(integer_part),
                                        int'(expected_digits[0].integer_part));
                    if (digit != expected_digits[0].digit)
                        report_mismatch("digit", int'(digit),
                                        int'(expected_digits[0].digit));
                    if (digit_index != expected_digits[0].digit_index)
                        report_mismatch("digit_index", int'(digit_index),
                                        int'(expected_digits[0].digit_index));
                    if (cycle_starts_here != expected_digits[0].cycle_starts_here)
                        report_mismatch("cycle_starts_here", int'(cycle_starts_here),
                                        int'(expected_digits[0].cycle_starts_here));
                    if (cycle_length != expected_digits[0].cycle_length)
                        report_mismatch("cycle_length", int'(cycle_length),
                                        int'(expected_digits[0].cycle_length));
                    if (truncated != expected_digits[0].truncated)
                        report_mismatch("truncated", int'(truncated),
                                        int'(expected_digits[0].truncated));
                    if (last != expected_digits[0].last)
                        report_mismatch("last", int'(last),
                                        int'(expected_digits[0].last));
                    void'(expected_digits.pop_front());
                end
            end
            out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // timeout
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // stimulus sequence
    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: field extremes and the special cases
        set_idling(0, 0);
        add_request(16'd0,     12'd1);     // zero numerator
        add_request(16'd0,     12'd4095);
        add_request(16'hFFFF,  12'd1);
        add_request(16'hFFFF,  12'd4095);
        add_request(16'd5,     12'd0);     // divide by zero
        add_request(16'hFFFF,  12'd0);
        add_request(16'd1,     12'd3);
        add_request(16'd1,     12'd4);     // terminating
        add_request(16'd1,     12'd6);     // cycle after one digit
        add_request(16'd22,    12'd7);
        add_request(16'd10,    12'd5);     // exact quotient
        add_request(16'd1,     12'd97);    // long, truncated
        add_request(16'd1,     12'd2048);  // long preamble
        add_request(16'd1,     12'd1536);
        add_request(16'd1,     12'd4095);
        add_request(16'd12345, 12'd4093);
        add_request(16'hAAAA,  12'h555);
        add_request(16'h5555,  12'hAAA);
        add_request(16'd41,    12'd81);
        add_request(16'd3,     12'd2);
        wait_drained();

        // random, no idling
        queue_random(RANDOM_PER_PHASE);
        wait_drained();

        // output held off while requests keep coming
        set_idling(0, 0);
        hold_arm = 1'b1;
        add_request(16'd1,   12'd97);
        add_request(16'd7,   12'd13);
        add_request(16'd100, 12'd37);
        add_request(16'd2,   12'd3);
        add_request(16'd999, 12'd41);
        add_request(16'd5,   12'd17);
        add_request(16'd0,   12'd9);
        add_request(16'd50,  12'd0);
        wait_drained();

        // random, sender mostly idle
        set_idling(84, 0);
        queue_random(RANDOM_PER_PHASE);
        wait_drained();

        // random, receiver mostly stalled
        set_idling(0, 84);
        queue_random(RANDOM_PER_PHASE);
        wait_drained();

        // random, light idling on both sides
        set_idling(7, 7);
        queue_random(RANDOM_PER_PHASE);
        wait_drained();

        // catch stray results after the last expected one
        set_idling(0, 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && expected_digits.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
